FILE: rtl/apu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apu_pkg
// Shared types and constants of the average predictor unfilter.
// ----------------------------------------------------------------------------
package apu_pkg;

   // pixel layout: blue in the lowest byte, then green, red, alpha
   localparam int CHAN_W   = 8;
   localparam int NUM_CHAN = 4;
   localparam int PIX_W    = CHAN_W * NUM_CHAN;
   localparam int ALPHA_CH = 3;

   // default row store depth
   localparam int MAX_WIDTH_DEF = 2048;

   // configuration port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;
   localparam int IMG_W_W    = 12;
   localparam int IMG_H_W    = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_HAS_ALPHA    = 2'd2
   } csr_index_type;

   // position of one pixel within the image
   typedef struct packed {
      logic first_row;
      logic first_col;
      logic row_end;
      logic image_end;
   } pos_type;

endpackage
`default_nettype wire

FILE: rtl/apu_row_mem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apu_row_mem
// Row store of rebuilt pixels: one write and one read port, registered read
// data, write data forwarded when both ports hit the same entry in a cycle.
// ----------------------------------------------------------------------------
module apu_row_mem #(
   parameter int DEPTH  = apu_pkg::MAX_WIDTH_DEF,
   parameter int DATA_W = apu_pkg::PIX_W,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [AW-1:0]     wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [AW-1:0]     rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, new data wins on a same-entry collision
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

FILE: rtl/apu_predict.sv
`default_nettype none
// ----------------------------------------------------------------------------
// apu_predict
// Per-channel predictor and residual subtraction for one pixel.
// ----------------------------------------------------------------------------
module apu_predict (
   input  wire logic [apu_pkg::PIX_W-1:0] res,
   input  wire logic [apu_pkg::PIX_W-1:0] above,
   input  wire logic [apu_pkg::PIX_W-1:0] left,
   input  wire apu_pkg::pos_type          pos,
   input  wire logic                      has_alpha,
   output logic      [apu_pkg::PIX_W-1:0] pix
);

   localparam int CW = apu_pkg::CHAN_W;

   // one independent lane per channel
   always_comb begin
      logic [CW:0]   sum;
      logic [CW-1:0] pred;
      logic [CW-1:0] r;
      pix = '0;
      for (int k = 0; k < apu_pkg::NUM_CHAN; k++) begin
         r   = res[k*CW +: CW];
         sum = {1'b0, above[k*CW +: CW]} + {1'b0, left[k*CW +: CW]};
         priority if (pos.first_row && pos.first_col) begin
            pred = '0;
         end else if (pos.first_row) begin
            pred = left[k*CW +: CW];
         end else if (pos.first_col) begin
            pred = above[k*CW +: CW];
         end else begin
            pred = sum[CW:1];
         end
         // first pixel of the image passes as is
         if (pos.first_row && pos.first_col) begin
            pix[k*CW +: CW] = r;
         end else begin
            pix[k*CW +: CW] = pred - r;
         end
         // alpha lane is zero when not in use
         if ((k == apu_pkg::ALPHA_CH) && !has_alpha) begin
            pix[k*CW +: CW] = '0;
         end
      end
   end

endmodule
`default_nettype wire

FILE: rtl/average_predictor_unfilter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// average_predictor_unfilter
// Rebuilds raster-order pixels from average-predictor residuals.
// ----------------------------------------------------------------------------
// One pixel beat is taken per cycle while the output is not stalled, and its
// result passes the rebuild stage registers and then the output register: the
// beat's column reads the row store as it is accepted, the pixel is rebuilt
// from the registered above value and the previous pixel and lands in the
// output register, writing the row store at the same time. The single read and
// single write port of the row store set this one pixel per cycle rate. The
// row store holds MAX_WIDTH pixels and needs no clearing. rsp_tlast marks the
// last pixel of a row, rsp_tuser the last pixel of the image, after which the
// next beat starts a new image.
// ----------------------------------------------------------------------------
module average_predictor_unfilter #(
   parameter int MAX_WIDTH = apu_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // residual beats
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // res_blue, res_green, res_red, res_alpha from bit 0 up
   input  wire logic [apu_pkg::PIX_W-1:0]      req_tdata,
   // rebuilt pixel beats
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // pix_blue, pix_green, pix_red, pix_alpha from bit 0 up
   output logic      [apu_pkg::PIX_W-1:0]      rsp_tdata,
   // row_end
   output logic                                rsp_tlast,
   // image_end
   output logic                                rsp_tuser,
   // register writes
   input  wire logic                           csr_we,
   input  wire logic [apu_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [apu_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW   = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int CMPW = ((CW > apu_pkg::IMG_W_W) ? CW : apu_pkg::IMG_W_W) + 1;
   localparam int PW   = apu_pkg::PIX_W;
   localparam int HW   = apu_pkg::IMG_H_W;

   // configuration registers
   logic [apu_pkg::IMG_W_W-1:0] width_ff;
   logic [HW-1:0]               height_ff;
   logic                        alpha_ff;

   // position counters for the next beat
   logic [CW-1:0] col_ff, col_in;
   logic [HW-1:0] row_ff, row_in;

   // rebuild stage
   logic              s1_valid_ff;
   logic [PW-1:0]     s1_res_ff;
   logic [CW-1:0]     s1_col_ff;
   apu_pkg::pos_type  s1_pos_ff;
   apu_pkg::pos_type  pos_in;
   logic [PW-1:0]     left_ff;

   // output register
   logic          rsp_valid_ff;
   logic [PW-1:0] rsp_pix_ff;
   logic          rsp_row_end_ff;
   logic          rsp_image_end_ff;

   logic          req_accept;
   logic          s1_advance;
   logic [PW-1:0] above;
   logic [PW-1:0] pix;

   logic [CMPW-1:0] w_eff;
   logic [CMPW-1:0] col_ext;
   logic [HW-1:0]   h_eff;

   // register writes, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= apu_pkg::IMG_W_W'(1);
         height_ff <= HW'(1);
         alpha_ff  <= 1'b0;
      end else if (csr_we) begin
         unique case (apu_pkg::csr_index_type'(csr_addr))
            apu_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[apu_pkg::IMG_W_W-1:0];
            apu_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[HW-1:0];
            apu_pkg::CSR_HAS_ALPHA:    alpha_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // handshakes
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;

   // effective image size
   always_comb begin
      w_eff = CMPW'(width_ff);
      if (w_eff == '0) begin
         w_eff = CMPW'(1);
      end else if (w_eff > CMPW'(MAX_WIDTH)) begin
         w_eff = CMPW'(MAX_WIDTH);
      end
      h_eff = (height_ff == '0) ? HW'(1) : height_ff;
   end

   // position of the beat being accepted and the counters after it
   always_comb begin
      col_ext          = CMPW'(col_ff);
      pos_in.first_row = (row_ff == '0);
      pos_in.first_col = (col_ff == '0);
      pos_in.row_end   = (col_ext >= (w_eff - CMPW'(1)));
      pos_in.image_end = pos_in.row_end && (row_ff >= (h_eff - HW'(1)));
      if (pos_in.row_end) begin
         col_in = '0;
         row_in = pos_in.image_end ? '0 : row_ff + HW'(1);
      end else begin
         col_in = col_ff + CW'(1);
         row_in = row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (req_accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // rebuild stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_res_ff <= req_tdata;
         s1_col_ff <= col_ff;
         s1_pos_ff <= pos_in;
      end
   end

   // row store, read ahead at acceptance
   apu_row_mem #(
      .DEPTH  (MAX_WIDTH),
      .DATA_W (PW)
   ) u_row_mem (
      .clock   (clock),
      .wr_en   (s1_advance),
      .wr_addr (s1_col_ff),
      .wr_data (pix),
      .rd_en   (req_accept),
      .rd_addr (col_ff),
      .rd_data (above)
   );

   apu_predict u_predict (
      .res       (s1_res_ff),
      .above     (above),
      .left      (left_ff),
      .pos       (s1_pos_ff),
      .has_alpha (alpha_ff),
      .pix       (pix)
   );

   // previous rebuilt pixel
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (s1_advance) begin
         left_ff <= pix;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_pix_ff       <= pix;
         rsp_row_end_ff   <= s1_pos_ff.row_end;
         rsp_image_end_ff <= s1_pos_ff.image_end;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_pix_ff;
   assign rsp_tlast  = rsp_row_end_ff;
   assign rsp_tuser  = rsp_image_end_ff;

   // the last pixel of an image always ends its row
   a_image_end_row: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (!rsp_tuser || rsp_tlast))
      else $error("image end without row end");

   // a beat that ends the image restarts both counters
   a_image_wrap: assert property (@(posedge clock) disable iff (reset)
      (req_accept && pos_in.image_end) |=> ((col_ff == '0) && (row_ff == '0)))
      else $error("counters did not wrap at image end");

   // a rebuilt pixel always lands in the output register
   a_stage_to_out: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_tvalid)
      else $error("rebuilt pixel lost");

   // a stalled rebuild stage keeps its beat
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_advance) |=> (s1_valid_ff && $stable(s1_col_ff)))
      else $error("stalled pixel dropped");

endmodule
`default_nettype wire
